>>> design/npm_pkg.sv
// Shared types and constants for the nearest prototype matcher.
// Used by npm_ctrl, npm_dp and nearest_prototype_norm_match.
`timescale 1ns / 1ps

package npm_pkg;

	typedef struct packed {
		logic               action;
		logic [8:0]         class_num;
		logic               noise_request;
		logic signed [15:0] y_value;
		logic signed [15:0] rx_value;
		logic signed [15:0] ry_value;
		logic signed [15:0] length_value;
		logic [15:0]        weight_y;
		logic [15:0]        weight_rx;
		logic [15:0]        weight_ry;
	} in_item_t;

	typedef struct packed {
		logic [15:0] score;
		logic [31:0] best_distance;
		logic [1:0]  status;
	} out_item_t;

	localparam logic        ACT_APPEND = 1'b0;
	localparam logic        ACT_MATCH  = 1'b1;

	localparam logic [1:0]  STATUS_MATCH  = 2'd0;
	localparam logic [1:0]  STATUS_NOISE  = 2'd1;
	localparam logic [1:0]  STATUS_APPEND = 2'd2;
	localparam logic [1:0]  STATUS_DROP   = 2'd3;

	localparam logic [1:0]  CFG_MIDPOINT = 2'd0;
	localparam logic [1:0]  CFG_CURL     = 2'd1;
	localparam logic [1:0]  CFG_CLASSES  = 2'd2;

	localparam logic [15:0] MIDPOINT_RST = 16'd8192;
	localparam logic [1:0]  CURL_RST     = 2'd2;
	localparam logic [9:0]  CLASSES_RST  = 10'd512;
	localparam logic [1:0]  CURL_CUBE    = 2'd3;

	localparam logic [15:0] NOISE_LEN_K = 16'd500;
	localparam logic [15:0] NOISE_MOM_K = 16'd8000;

	localparam logic [31:0] SAT32  = 32'hFFFF_FFFF;
	localparam logic [24:0] XCLAMP = 25'h100_0000;
	localparam logic [15:0] SCORE_FULL = 16'hFFFF;

	localparam logic [4:0]  DIV_RATIO_STEPS = 5'd24;
	localparam logic [4:0]  DIV_SCORE_STEPS = 5'd16;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CNT,
		ST_DECIDE,
		ST_SQ,
		ST_MUL,
		ST_ACC,
		ST_NEXT,
		ST_DIV1,
		ST_POW1,
		ST_POW2,
		ST_SCORE,
		ST_DIV2,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		RK_MATCH,
		RK_EMPTY,
		RK_NOISE,
		RK_APPEND,
		RK_DROP
	} res_kind_t;

	typedef struct packed {
		logic      cap;
		logic      clr_wr;
		logic      app_wr;
		logic      best_init;
		logic      sq_en;
		logic      mul_en;
		logic      acc_en;
		logic      k_inc;
		logic      div_ratio_start;
		logic      div_score_start;
		logic      div_step;
		logic      pow_sq;
		logic      pow_cube;
		logic      res_load;
		res_kind_t res_kind;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_append;
		logic is_noise;
		logic full;
		logic empty;
		logic k_last;
		logic div_last;
		logic cube;
		logic out_free;
	} sts_t;

endpackage

>>> design/npm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module npm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
	output logic [WIDTH-1:0]                              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/npm_ctrl.sv
// Sequencing controller for the nearest prototype matcher.
// Depends on npm_pkg; drives npm_dp through cmd_t, reads sts_t.
`timescale 1ns / 1ps

module npm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  npm_pkg::sts_t sts,
	output npm_pkg::cmd_t cmd
);
	import npm_pkg::*;

	state_t    state_q, state_d;
	res_kind_t kind_q, kind_d;

	always_comb begin
		if (sts.is_append) begin
			kind_d = sts.full ? RK_DROP : RK_APPEND;
		end else if (sts.is_noise) begin
			kind_d = RK_NOISE;
		end else if (sts.empty) begin
			kind_d = RK_EMPTY;
		end else begin
			kind_d = RK_MATCH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			kind_q  <= RK_MATCH;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DECIDE) begin
				kind_q <= kind_d;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:  if (sts.clr_last) state_d = ST_IDLE;
			ST_IDLE:   if (in_valid) state_d = ST_CNT;
			ST_CNT:    state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (kind_d == RK_NOISE || kind_d == RK_MATCH) begin
					state_d = ST_SQ;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_SQ:     state_d = ST_MUL;
			ST_MUL:    state_d = ST_ACC;
			ST_ACC:    state_d = (sts.is_noise || sts.k_last) ? ST_DIV1 : ST_NEXT;
			ST_NEXT:   state_d = ST_SQ;
			ST_DIV1:   if (sts.div_last) state_d = ST_POW1;
			ST_POW1:   state_d = sts.cube ? ST_POW2 : ST_SCORE;
			ST_POW2:   state_d = ST_SCORE;
			ST_SCORE:  state_d = ST_DIV2;
			ST_DIV2:   if (sts.div_last) state_d = ST_OUT;
			ST_OUT:    if (sts.out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd          = '0;
		cmd.res_kind = kind_q;
		in_ready     = 1'b0;
		case (state_q)
			ST_CLEAR:  cmd.clr_wr = 1'b1;
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.cap  = in_valid;
			end
			ST_DECIDE: begin
				cmd.app_wr    = (kind_d == RK_APPEND);
				cmd.best_init = 1'b1;
			end
			ST_SQ:     cmd.sq_en = 1'b1;
			ST_MUL:    cmd.mul_en = 1'b1;
			ST_ACC: begin
				cmd.acc_en = 1'b1;
				if (sts.is_noise || sts.k_last) begin
					cmd.div_ratio_start = 1'b1;
				end else begin
					cmd.k_inc = 1'b1;
				end
			end
			ST_DIV1:   cmd.div_step = 1'b1;
			ST_POW1:   cmd.pow_sq = 1'b1;
			ST_POW2:   cmd.pow_cube = 1'b1;
			ST_SCORE:  cmd.div_score_start = 1'b1;
			ST_DIV2:   cmd.div_step = 1'b1;
			ST_OUT:    cmd.res_load = sts.out_free;
			default:   cmd = '0;
		endcase
	end

endmodule

>>> design/npm_dp.sv
// Datapath: prototype and count memories, distance lanes, shared divider
// and power multiplier, result register. Depends on npm_pkg and npm_ram.
`timescale 1ns / 1ps

module npm_dp #(
	parameter int NUM_CLASSES      = 512,
	parameter int PROTOS_PER_CLASS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  npm_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output npm_pkg::out_item_t out_data,
	input  npm_pkg::cmd_t      cmd,
	output npm_pkg::sts_t      sts
);
	import npm_pkg::*;

	localparam int CIW   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int SLOTS = NUM_CLASSES * PROTOS_PER_CLASS;
	localparam int SAW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW    = $clog2(PROTOS_PER_CLASS + 1);

	// configuration
	logic [15:0] midpoint_q;
	logic [1:0]  curl_q;
	logic [9:0]  classes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			midpoint_q <= MIDPOINT_RST;
			curl_q     <= CURL_RST;
			classes_q  <= CLASSES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIDPOINT: midpoint_q <= cfg_data;
				CFG_CURL:     curl_q     <= cfg_data[1:0];
				CFG_CLASSES:  classes_q  <= cfg_data[9:0];
				default:      ;
			endcase
		end
	end

	// captured word
	in_item_t item_q;
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			item_q <= in_data;
		end
	end

	logic           in_range;
	logic [CIW-1:0] cls_idx;
	assign in_range = 32'(item_q.class_num) < NUM_CLASSES;
	assign cls_idx  = CIW'(item_q.class_num);

	// clearing pass over the count memory after reset
	logic [CIW-1:0] clr_ptr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_ptr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_ptr_q <= clr_ptr_q + CIW'(1);
		end
	end

	// count memory
	logic [CW-1:0]  cnt_rd;
	logic           cnt_we;
	logic [CIW-1:0] cnt_waddr;
	logic [CW-1:0]  cnt_wdata;
	assign cnt_we    = cmd.clr_wr | cmd.app_wr;
	assign cnt_waddr = cmd.clr_wr ? clr_ptr_q : cls_idx;
	assign cnt_wdata = cmd.clr_wr ? '0 : cnt_rd + CW'(1);

	npm_ram #(.WIDTH(CW), .DEPTH(NUM_CLASSES)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (cls_idx),
		.rdata (cnt_rd)
	);

	// prototype memory: {w_y, w_rx, w_ry, y, rx, ry}
	logic [CW-1:0]  k_q;
	logic [SAW-1:0] base_addr, rd_addr, wr_addr;
	logic [95:0]    proto_rd;
	assign base_addr = SAW'(cls_idx) * SAW'(PROTOS_PER_CLASS);
	assign rd_addr   = base_addr + SAW'(k_q);
	assign wr_addr   = base_addr + SAW'(cnt_rd);

	npm_ram #(.WIDTH(96), .DEPTH(SLOTS)) u_proto_ram (
		.clk   (clk),
		.we    (cmd.app_wr),
		.waddr (wr_addr),
		.wdata ({item_q.weight_y, item_q.weight_rx, item_q.weight_ry,
			item_q.y_value, item_q.rx_value, item_q.ry_value}),
		.raddr (rd_addr),
		.rdata (proto_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (cmd.cap) begin
			k_q <= '0;
		end else if (cmd.k_inc) begin
			k_q <= k_q + CW'(1);
		end
	end

	logic is_noise;
	assign is_noise = item_q.noise_request || ({1'b0, item_q.class_num} >= classes_q)
		|| !in_range;

	// distance lanes: y, rx, ry (noise: length, rx, ry)
	logic signed [15:0] feat [3];
	logic signed [15:0] mean [3];
	logic [15:0]        wgt  [3];
	logic [15:0]        sq_in [3];
	logic [31:0]        sq_s1 [3];
	logic [47:0]        prod_s2 [3];

	assign feat[0] = is_noise ? item_q.length_value : item_q.y_value;
	assign feat[1] = item_q.rx_value;
	assign feat[2] = item_q.ry_value;
	assign mean[0] = proto_rd[47:32];
	assign mean[1] = proto_rd[31:16];
	assign mean[2] = proto_rd[15:0];
	assign wgt[0]  = is_noise ? NOISE_LEN_K : proto_rd[95:80];
	assign wgt[1]  = is_noise ? NOISE_MOM_K : proto_rd[79:64];
	assign wgt[2]  = is_noise ? NOISE_MOM_K : proto_rd[63:48];

	for (genvar i = 0; i < 3; i++) begin : g_lane
		logic signed [16:0] delta;
		logic [16:0]        mag;
		assign delta = is_noise ? 17'(feat[i]) : 17'(feat[i]) - 17'(mean[i]);
		assign mag   = delta[16] ? 17'(-delta) : 17'(delta);
		assign sq_in[i] = mag[15:0];

		always_ff @(posedge clk) begin
			if (cmd.sq_en) begin
				sq_s1[i] <= sq_in[i] * sq_in[i];
			end
			if (cmd.mul_en) begin
				prod_s2[i] <= sq_s1[i] * wgt[i];
			end
		end
	end

	logic [49:0] sum_m, sum_n;
	logic [31:0] cand_dist;
	assign sum_m = 50'(prod_s2[0]) + 50'(prod_s2[1]) + 50'(prod_s2[2][47:3]);
	assign sum_n = 50'(prod_s2[0]) + 50'(prod_s2[1]) + 50'(prod_s2[2]);
	always_comb begin
		if (is_noise) begin
			cand_dist = (sum_n[49:40] != '0) ? SAT32 : sum_n[39:8];
		end else begin
			cand_dist = (sum_m[49:48] != '0) ? SAT32 : sum_m[47:16];
		end
	end

	logic [31:0] best_q;
	always_ff @(posedge clk) begin
		if (cmd.best_init) begin
			best_q <= SAT32;
		end else if (cmd.acc_en && cand_dist < best_q) begin
			best_q <= cand_dist;
		end
	end

	// shared restoring divider, one quotient bit per cycle
	logic [32:0] rem_q, dvs_q;
	logic [23:0] shin_q, quo_q;
	logic [4:0]  div_cnt_q;
	logic        clamp_q;
	logic [33:0] trial;
	logic        qbit;
	assign trial = {rem_q, shin_q[23]};
	assign qbit  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_ratio_start) begin
			div_cnt_q <= DIV_RATIO_STEPS;
		end else if (cmd.div_score_start) begin
			div_cnt_q <= DIV_SCORE_STEPS;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q - 5'd1;
		end
	end

	logic [31:0] pow_q;
	always_ff @(posedge clk) begin
		if (cmd.div_ratio_start) begin
			// acc_en updates best in the same cycle, so take the min here
			rem_q   <= 33'((cand_dist < best_q ? cand_dist : best_q) >> 16);
			shin_q  <= {(cand_dist < best_q ? cand_dist[15:0] : best_q[15:0]), 8'd0};
			dvs_q   <= 33'(midpoint_q);
			clamp_q <= (cand_dist < best_q ? cand_dist[31:16] : best_q[31:16])
				>= midpoint_q;
			quo_q   <= '0;
		end else if (cmd.div_score_start) begin
			rem_q  <= 33'(pow_q);
			shin_q <= '0;
			dvs_q  <= 33'(pow_q) + 33'd65536;
			quo_q  <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= qbit ? 33'(trial - {1'b0, dvs_q}) : trial[32:0];
			shin_q <= {shin_q[22:0], 1'b0};
			quo_q  <= {quo_q[22:0], qbit};
		end
	end

	// power: x*x, then optionally *x, one product per cycle
	logic [24:0] xsel, x_q;
	logic [31:0] mul_a;
	logic [24:0] mul_b;
	logic [56:0] mul_p;
	assign xsel  = clamp_q ? XCLAMP : {1'b0, quo_q};
	assign mul_a = cmd.pow_sq ? 32'(xsel) : pow_q;
	assign mul_b = cmd.pow_sq ? xsel : x_q;
	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (cmd.pow_sq || cmd.pow_cube) begin
			pow_q <= (mul_p[56:48] != '0) ? SAT32 : mul_p[47:16];
		end
		if (cmd.pow_sq) begin
			x_q <= xsel;
		end
	end

	// result register
	logic      out_valid_q;
	out_item_t out_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			case (cmd.res_kind)
				RK_MATCH:  out_q <= '{quo_q[15:0], best_q, STATUS_MATCH};
				RK_EMPTY:  out_q <= '{SCORE_FULL, SAT32, STATUS_MATCH};
				RK_NOISE:  out_q <= '{quo_q[15:0], best_q, STATUS_NOISE};
				RK_APPEND: out_q <= '{16'd0, 32'd0, STATUS_APPEND};
				RK_DROP:   out_q <= '{16'd0, 32'd0, STATUS_DROP};
				default:   out_q <= '{16'd0, 32'd0, STATUS_DROP};
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign sts.clr_last  = clr_ptr_q == CIW'(NUM_CLASSES - 1);
	assign sts.is_append = item_q.action == ACT_APPEND;
	assign sts.is_noise  = is_noise;
	assign sts.full      = !in_range || (32'(cnt_rd) >= PROTOS_PER_CLASS);
	assign sts.empty     = cnt_rd == '0;
	assign sts.k_last    = (k_q + CW'(1)) == cnt_rd;
	assign sts.div_last  = div_cnt_q == 5'd1;
	assign sts.cube      = curl_q == CURL_CUBE;
	assign sts.out_free  = !out_valid_q || out_ready;

	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> div_cnt_q != 5'd0)
		else $error("divider stepped with no iterations left");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken word");

	a_best_min: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.acc_en && !cmd.best_init) |=> best_q <= $past(best_q))
		else $error("best distance grew during a match");

endmodule

>>> design/nearest_prototype_norm_match.sv
// Top level of the nearest prototype matcher.
// Depends on npm_pkg, npm_ctrl, npm_dp (which uses npm_ram).
`timescale 1ns / 1ps

// Keeps up to PROTOS_PER_CLASS prototypes for each of NUM_CLASSES classes and
// handles one word at a time. An append reads the class count, then stores the
// prototype unless the class is full. A match walks the class's n prototypes
// through a shared three-lane square/multiply path, then runs a bit-serial
// divider twice (a 24-bit quotient for the distance ratio, 16 bits for the
// score) around one power product, two for the cube; a noise word makes a
// single pass. An empty class answers without a distance pass. After reset the
// per-class counts are cleared, one class per cycle, before the first word is
// taken; configuration is to be written only while no word is in flight. A
// finished result sits in an output register, so the next word is taken while
// it waits; that word's result holds the block until the first is taken.
module nearest_prototype_norm_match #(
	parameter int NUM_CLASSES      = 512,
	parameter int PROTOS_PER_CLASS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  npm_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output npm_pkg::out_item_t out_data
);
	import npm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	npm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	npm_dp #(
		.NUM_CLASSES      (NUM_CLASSES),
		.PROTOS_PER_CLASS (PROTOS_PER_CLASS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
